/* rtl/integer_power_mod_width_core_defines.svh */
// Assertion macros shared by the checker files of the integer power core.
// Depends on nothing; included by bare file name.
`ifndef INTEGER_POWER_MOD_WIDTH_CORE_DEFINES_SVH
`define INTEGER_POWER_MOD_WIDTH_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define IPM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("integer power core: assertion failed");

// Check that a condition leads to a consequence in the next cycle
`define IPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  `IPM_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

/* rtl/ipm_pkg.sv */
// Shared types, codes and helper functions of the integer power core.
// No dependencies; imported by the interfaces and every module.
package ipm_pkg;

  localparam int unsigned MaxWidth = 32;
  localparam int unsigned NumSteps = MaxWidth;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Element size codes; the unused code behaves as word
  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeHalf = 2'd1;
  localparam logic [1:0] SizeWord = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegElementSize    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegExponentSigned = CfgIdxW'(1);

  typedef logic [MaxWidth-1:0] word_t;

  // One square-and-multiply stage word
  typedef struct packed {
    logic       valid;
    word_t      acc;
    word_t      sq;
    word_t      expo;
    logic [1:0] size;
    logic       last;
  } step_t;

  // Mask of the element width
  function automatic word_t width_mask(logic [1:0] size);
    word_t m;
    case (size)
      SizeByte: m = word_t'(8'hFF);
      SizeHalf: m = word_t'(16'hFFFF);
      default:  m = '1;
    endcase
    return m;
  endfunction

  // Sign bit of an element of the given width
  function automatic logic sign_of(word_t e, logic [1:0] size);
    logic s;
    case (size)
      SizeByte: s = e[7];
      SizeHalf: s = e[15];
      default:  s = e[MaxWidth-1];
    endcase
    return s;
  endfunction

endpackage

/* rtl/ipm_if.sv */
// Valid/ready channel interfaces of the integer power core.
// Depends on ipm_pkg.
interface ipm_in_if import ipm_pkg::*;;
  logic  valid;
  logic  ready;
  word_t base_value;
  word_t exponent_value;
  logic  last_element;

  modport source (output valid, base_value, exponent_value, last_element, input ready);
  modport sink   (input valid, base_value, exponent_value, last_element, output ready);
endinterface

interface ipm_out_if import ipm_pkg::*;;
  logic  valid;
  logic  ready;
  word_t power_result;
  logic  last_out;

  modport source (output valid, power_result, last_out, input ready);
  modport sink   (input valid, power_result, last_out, output ready);
endinterface

interface ipm_cfg_if import ipm_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/integer_power_mod_width_core.sv */
// Stages: the entry stage plus one register stage per exponent bit, 32 in all.
// Throughput: one word per cycle; the whole pipeline holds while a result waits.
// Reset clears every valid bit and sets element size to word, exponent signed.
// Configuration words are taken in every cycle.
module integer_power_mod_width_core import ipm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  ipm_cfg_if.sink  cfg_i,
  ipm_in_if.sink   item_i,
  ipm_out_if.source result_o
);

  logic [1:0] element_size_q;
  logic [1:0] element_size_d;
  logic       exponent_signed_q;
  logic       exponent_signed_d;
  logic       en;
  step_t      stage_s [0:NumSteps];

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_comb begin
    element_size_d    = element_size_q;
    exponent_signed_d = exponent_signed_q;
    if (cfg_i.valid && (cfg_i.index == RegElementSize)) begin
      element_size_d = cfg_i.data[1:0];
    end
    if (cfg_i.valid && (cfg_i.index == RegExponentSigned)) begin
      exponent_signed_d = cfg_i.data[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_size_q    <= SizeWord;
      exponent_signed_q <= 1'b1;
    end else begin
      element_size_q    <= element_size_d;
      exponent_signed_q <= exponent_signed_d;
    end
  end

  // Advance the pipeline unless the output word is held
  assign en           = !stage_s[NumSteps].valid || result_o.ready;
  assign item_i.ready = en;

  ipm_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (item_i.valid),
    .base_i   (item_i.base_value),
    .exp_i    (item_i.exponent_value),
    .last_i   (item_i.last_element),
    .size_i   (element_size_q),
    .signed_i (exponent_signed_q),
    .stage_o  (stage_s[0])
  );

  for (genvar k = 0; k < NumSteps; k++) begin : g_step
    ipm_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (stage_s[k]),
      .stage_o (stage_s[k+1])
    );
  end

  // Drive the output word from the last stage, trimmed to the element width
  assign result_o.valid        = stage_s[NumSteps].valid;
  assign result_o.power_result = stage_s[NumSteps].acc & width_mask(stage_s[NumSteps].size);
  assign result_o.last_out     = stage_s[NumSteps].last;

endmodule

/* rtl/ipm_prep.sv */
// Entry stage: masks operands to the element width and forms the exponent magnitude.
// Depends on ipm_pkg.
module ipm_prep import ipm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  word_t      base_i,
  input  word_t      exp_i,
  input  logic       last_i,
  input  logic [1:0] size_i,
  input  logic       signed_i,
  output step_t      stage_o
);

  word_t mask;
  word_t exp_m;
  word_t exp_mag;
  step_t stage_d;
  step_t stage_q;

  // Take the magnitude of a negative signed exponent; the most negative stays 2^(w-1)
  always_comb begin
    mask    = width_mask(size_i);
    exp_m   = exp_i & mask;
    exp_mag = (signed_i && sign_of(exp_m, size_i)) ? ((~exp_m + word_t'(1)) & mask) : exp_m;
    stage_d.valid = valid_i;
    stage_d.acc   = word_t'(1);
    stage_d.sq    = base_i & mask;
    stage_d.expo  = exp_mag;
    stage_d.size  = size_i;
    stage_d.last  = last_i;
  end

  // Load the stage word when enabled; reset clears it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

/* rtl/ipm_step.sv */
// One square-and-multiply stage: consumes the lowest exponent bit.
// Depends on ipm_pkg.
module ipm_step import ipm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  step_t stage_i,
  output step_t stage_o
);

  logic [2*MaxWidth-1:0] acc_prod;
  logic [2*MaxWidth-1:0] sq_prod;
  step_t                 stage_d;
  step_t                 stage_q;

  // Multiply in when the exponent bit is set, square the base, shift the exponent
  always_comb begin
    acc_prod      = stage_i.acc * stage_i.sq;
    sq_prod       = stage_i.sq * stage_i.sq;
    stage_d       = stage_i;
    stage_d.acc   = stage_i.expo[0] ? acc_prod[MaxWidth-1:0] : stage_i.acc;
    stage_d.sq    = sq_prod[MaxWidth-1:0];
    stage_d.expo  = stage_i.expo >> 1;
  end

  // Load the stage word when enabled; reset clears it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

/* rtl/ipm_checker.sv */
// Port-level checks of the integer power core, bound to the top level.
// Depends on ipm_pkg and integer_power_mod_width_core_defines.svh.
`include "integer_power_mod_width_core_defines.svh"

module ipm_checker import ipm_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input word_t out_power_result_i,
  input logic  out_last_i
);

  // Input is taken exactly when the output word is free or leaving
  `IPM_ASSERT(a_in_ready_follows_out, clk_i, rst_ni, in_ready_i == (!out_valid_i || out_ready_i))

  // A held output word stays valid
  `IPM_ASSERT_NEXT(a_out_valid_held, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // A held output word keeps its payload
  `IPM_ASSERT_NEXT(a_out_payload_held, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_power_result_i) && $stable(out_last_i))

  // A stalled input side sees the output word stay valid
  `IPM_ASSERT_NEXT(a_no_in_no_out_change, clk_i, rst_ni, in_valid_i && !in_ready_i, out_valid_i)

endmodule

bind integer_power_mod_width_core ipm_checker u_ipm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (item_i.valid),
  .in_ready_i         (item_i.ready),
  .out_valid_i        (result_o.valid),
  .out_ready_i        (result_o.ready),
  .out_power_result_i (result_o.power_result),
  .out_last_i         (result_o.last_out)
);

/* test/testbench.sv */
// Self-checking testbench of the integer power core: directed and random words
// through the item channel, register writes between phases, results checked in order.
// Depends on ipm_pkg, the channel interfaces in ipm_if.sv and integer_power_mod_width_core.
module testbench;
  import ipm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 40;

  typedef struct {
    word_t power;
    logic  last;
  } power_word_t;

  logic clk_i;
  logic rst_ni;

  ipm_cfg_if cfg_bus ();
  ipm_in_if  item_bus ();
  ipm_out_if result_bus ();

  integer_power_mod_width_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  // Register copies, as last written
  logic [1:0]  size_reg;
  logic        signed_reg;

  power_word_t pending_powers[$];
  power_word_t want;
  int          error_count;
  int          cycle_count;
  bit          idle_on;
  int          hold_cycles;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stop a run that hangs
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mask of the element width
  function automatic word_t element_mask(logic [1:0] size);
    word_t m;
    case (size)
      SizeByte: m = word_t'(32'h0000_00FF);
      SizeHalf: m = word_t'(32'h0000_FFFF);
      default:  m = '1;
    endcase
    return m;
  endfunction

  // Base to the exponent magnitude, wrapped to the element width
  function automatic word_t predict_power(word_t base, word_t expo, logic [1:0] size,
                                          logic sgn);
    logic [63:0] m;
    logic [63:0] e;
    logic [63:0] acc;
    logic [63:0] sq;
    m = 64'(element_mask(size));
    e = 64'(expo) & m;
    if (sgn && ((e & (m ^ (m >> 1))) != 64'd0)) e = (~e + 64'd1) & m;
    acc = 64'd1;
    sq = 64'(base) & m;
    while (e != 64'd0) begin
      if (e[0]) acc = (acc * sq) & m;
      sq = (sq * sq) & m;
      e = e >> 1;
    end
    return word_t'(acc & m);
  endfunction

  // Drive the ready of the result side: hold-off first, then random stall bursts
  initial begin
    result_bus.ready = 1'b0;
    forever begin : ready_drive
      int stall_left;
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        result_bus.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        result_bus.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (pending_powers.size() == 0) begin
        $display("%0t: unexpected result power %h last %b", $time,
                 result_bus.power_result, result_bus.last_out);
        error_count++;
      end else begin
        want = pending_powers.pop_front();
        if (result_bus.power_result !== want.power) begin
          $display("%0t: power_result expected %h actual %h", $time, want.power,
                   result_bus.power_result);
          error_count++;
        end
        if (result_bus.last_out !== want.last) begin
          $display("%0t: last_out expected %b actual %b", $time, want.last,
                   result_bus.last_out);
          error_count++;
        end
      end
    end
  end

  // Offer one word, hold it until taken, then log its prediction
  task automatic send_word(input word_t base, input word_t expo, input logic last);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 3);
    repeat (gap) begin
      @(negedge clk_i);
      item_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    item_bus.valid          <= 1'b1;
    item_bus.base_value     <= base;
    item_bus.exponent_value <= expo;
    item_bus.last_element   <= last;
    do @(posedge clk_i); while (!item_bus.ready);
    pending_powers.push_back('{predict_power(base, expo, size_reg, signed_reg), last});
  endtask

  // Random word with weight on small and boundary exponents
  task automatic send_random_word();
    word_t m;
    word_t b;
    word_t e;
    int    pick;
    m = element_mask(size_reg);
    b = $urandom;
    pick = $urandom_range(0, 15);
    if (pick < 2) b = (b & ~m) | word_t'($urandom_range(0, 3));
    else if (pick == 2) b = b | m;
    e = $urandom;
    pick = $urandom_range(0, 15);
    if (pick < 4) e = (e & ~m) | word_t'($urandom_range(0, 40));
    else if (pick == 4) e = (e & ~m) | (m ^ (m >> 1));
    else if (pick == 5) e = e | m;
    else if (pick == 6) e = e & ~m;
    else if (pick == 7) e = (e & ~m) | (m >> 1);
    send_word(b, e, 1'($urandom_range(0, 1)));
  endtask

  // Drop valid and wait for every predicted word to come back
  task automatic drain_results();
    @(negedge clk_i);
    item_bus.valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk_i);
  endtask

  // Write one register; upper data bits are random noise
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [1:0] value);
    logic [CfgDataW-1:0] data;
    data = ($urandom & ~32'h3) | CfgDataW'(value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    if (idx == RegElementSize) size_reg = data[1:0];
    else if (idx == RegExponentSigned) signed_reg = data[0];
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic write_settings(input logic [1:0] size, input logic sgn);
    write_register(RegElementSize, size);
    write_register(RegExponentSigned, {1'b0, sgn});
  endtask

  // Boundary words under reset settings, then byte, half and the unused size code
  task automatic test_directed();
    send_word(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 32'h0000_0001, 1'b1);
    send_word(32'h0000_0002, 32'h0000_001F, 1'b0);
    send_word(32'h0000_0002, 32'h0000_0020, 1'b0);
    send_word(32'h0000_0003, 32'h8000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_word(32'h1234_5679, 32'hFFFF_FFFE, 1'b0);
    drain_results();
    write_settings(SizeByte, 1'b1);
    send_word(32'hABCD_1203, 32'hFFFF_FF80, 1'b0);
    send_word(32'h0000_0003, 32'h0000_00FF, 1'b1);
    send_word(32'hFFFF_FF02, 32'h5A5A_A57F, 1'b0);
    send_word(32'h0000_00FF, 32'h0000_0000, 1'b1);
    drain_results();
    write_settings(SizeByte, 1'b0);
    send_word(32'h0000_0003, 32'h0000_00FF, 1'b0);
    send_word(32'h0000_0003, 32'hFFFF_FF80, 1'b1);
    drain_results();
    write_settings(SizeHalf, 1'b1);
    send_word(32'h0001_0003, 32'h0000_8000, 1'b0);
    send_word(32'h0000_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_word(32'h0000_0005, 32'h0000_7FFF, 1'b0);
    drain_results();
    write_settings(2'd3, 1'b0);
    send_word(32'h0000_0003, 32'hFFFF_FFFF, 1'b0);
    send_word(32'h1234_5678, 32'h8000_0000, 1'b1);
    send_word(32'h0000_0007, 32'h8000_0001, 1'b0);
    drain_results();
  endtask

  // Random words under every size and sign setting
  task automatic test_random_settings();
    logic [1:0] size;
    logic       sgn;
    for (int s = 0; s < 4; s++) begin
      for (int g = 0; g < 2; g++) begin
        size = 2'(s);
        sgn = 1'(g ^ (s & 1));
        write_settings(size, sgn);
        repeat (200) send_random_word();
        drain_results();
      end
    end
  endtask

  // Long result hold-off fills the pipeline; then a pause until all words are back
  task automatic test_backpressure();
    write_settings(SizeWord, 1'b1);
    hold_cycles = 150;
    repeat (90) send_random_word();
    drain_results();
    write_settings(SizeHalf, 1'b0);
    repeat (30) send_random_word();
    drain_results();
  endtask

  // Back to back words with no idling on either side
  task automatic test_full_rate();
    idle_on = 1'b0;
    write_settings(SizeWord, 1'b0);
    repeat (200) send_random_word();
    drain_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    item_bus.valid = 1'b0;
    item_bus.base_value = '0;
    item_bus.exponent_value = '0;
    item_bus.last_element = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    size_reg = SizeWord;
    signed_reg = 1'b1;
    error_count = 0;
    idle_on = 1'b1;
    hold_cycles = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_settings();
    test_backpressure();
    test_full_rate();

    // Let any stray word show up before the verdict
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
